[hw/rtl/scd_pkg.sv]
package scd_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int ALPHA_W  = 16;
  localparam int SUPPLY_W = 12;
  localparam int RREF_W   = 20;
  localparam int CODE_W   = 12;
  localparam int RES_W    = 32;
  localparam int COND_W   = 24;
  localparam int DMV_W    = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA  = 2'd0,
    CFG_SUPPLY = 2'd1,
    CFG_RREF   = 2'd2
  } cfg_idx_t;

  localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 16'd6554;
  localparam logic [SUPPLY_W-1:0] SUPPLY_RST = 12'd3300;
  localparam logic [RREF_W-1:0]   RREF_RST   = 20'd100000;

  // Moving average format
  localparam int AVG_FRAC = 16;
  localparam int AVG_W    = SAMPLE_W + AVG_FRAC;

  // Shift-add multiplier geometry
  localparam int COND_SCALE_W = 27;
  localparam int MC_W         = (AVG_W > COND_SCALE_W) ? AVG_W : COND_SCALE_W;
  localparam int MP_W         = ALPHA_W + 1;
  localparam int PROD_W       = MC_W + MP_W;
  localparam int MUL_CNT_W    = $clog2(MP_W + 1);

  // Restoring divider geometry
  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Numerator widths of the three divisions
  localparam int CODE_NUM_W = SAMPLE_W + CODE_W;
  localparam int RES_NUM_W  = RREF_W + SAMPLE_W;
  localparam int CND_NUM_W  = COND_SCALE_W + SAMPLE_W;

  localparam logic [CODE_W-1:0]       CODE_MAX   = 12'd4095;
  localparam logic [COND_W-1:0]       COND_MAX   = 24'hFFFFFF;
  localparam logic [COND_SCALE_W-1:0] COND_SCALE = 27'd100000000;
  localparam logic [MP_W-1:0]         ALPHA_ONE  = 17'h10000;

  // EMA rounding and tenths-of-mV output scaling
  localparam int PA_W    = ALPHA_W + SAMPLE_W;
  localparam int RND_W   = PROD_W + 1;
  localparam int SUM_W   = PROD_W + 2;
  localparam int DMV_CW  = AVG_W + 4;
  localparam logic [RND_W-1:0]  ROUND_HALF = RND_W'(1) << (ALPHA_W - 1);
  localparam logic [DMV_CW-1:0] DMV_HALF   = DMV_CW'(1) << (AVG_FRAC - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_CODE_DIV,
    S_RES_MUL,
    S_RES_DIV,
    S_CND_MUL,
    S_CND_DIV,
    S_EMA,
    S_EMA_MA,
    S_EMA_MB,
    S_EMA_SUM,
    S_DONE
  } state_t;

endpackage

[hw/rtl/scd_div.sv]
module scd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [scd_pkg::DIV_NUM_W-1:0] num,
  input  logic [scd_pkg::DIV_DEN_W-1:0] den,
  input  logic [scd_pkg::DIV_CNT_W-1:0] steps,
  output logic                          done,
  output logic [scd_pkg::DIV_NUM_W-1:0] quo
);

  logic                          busy_r;
  logic                          done_r;
  logic [scd_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [scd_pkg::DIV_NUM_W-1:0] nq_r;
  logic [scd_pkg::DIV_DEN_W-1:0] rem_r;
  logic [scd_pkg::DIV_DEN_W-1:0] den_r;

  logic [scd_pkg::DIV_DEN_W:0]   rem_sh;
  logic [scd_pkg::DIV_DEN_W+1:0] trial;
  logic                          q_bit;

  // One quotient bit per cycle: shift in next numerator bit, trial subtract
  assign rem_sh = {rem_r, nq_r[scd_pkg::DIV_NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_r};
  assign q_bit  = ~trial[scd_pkg::DIV_DEN_W+1];

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - scd_pkg::DIV_CNT_W'(1);
        if (cnt_r == scd_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Numerator/quotient shift register and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      nq_r  <= {nq_r[scd_pkg::DIV_NUM_W-2:0], q_bit};
      rem_r <= q_bit ? trial[scd_pkg::DIV_DEN_W-1:0] : rem_sh[scd_pkg::DIV_DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = nq_r;

endmodule

[hw/rtl/scd_mul.sv]
module scd_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [scd_pkg::MC_W-1:0]   mcand,
  input  logic [scd_pkg::MP_W-1:0]   mplier,
  output logic                       done,
  output logic [scd_pkg::PROD_W-1:0] prod
);

  logic                          busy_r;
  logic                          done_r;
  logic [scd_pkg::MUL_CNT_W-1:0] cnt_r;
  logic [scd_pkg::MC_W-1:0]      mcand_r;
  logic [scd_pkg::PROD_W-1:0]    p_r;
  logic [scd_pkg::MC_W:0]        upper;

  // Add multiplicand into the upper half when the current multiplier bit is set
  assign upper = {1'b0, p_r[scd_pkg::PROD_W-1:scd_pkg::MP_W]}
               + (p_r[0] ? {1'b0, mcand_r} : '0);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= scd_pkg::MUL_CNT_W'(scd_pkg::MP_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - scd_pkg::MUL_CNT_W'(1);
        if (cnt_r == scd_pkg::MUL_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Product register: multiplier bits shift out at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      p_r     <= {{scd_pkg::MC_W{1'b0}}, mplier};
    end else if (busy_r) begin
      p_r <= {upper, p_r[scd_pkg::MP_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

[hw/rtl/skin_conductance_sample_conditioner.sv]
// Each sample: code division; if unclipped, resistance and conductance mul/div; then the EMA,
//   using a bit-serial divider (24-, 32-, 39-bit quotients) and 17-bit shift-add multiplies.
// Clipped samples skip resistance/conductance; the first sample skips the EMA multiplies.
// Flow: one sample at a time, taken only in idle; a finished result waits in the output
//   register while the next sample is taken.
// Reset (rst_n low, sync): state, config, out_valid reset; average restarts on next sample.
module skin_conductance_sample_conditioner (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [scd_pkg::SAMPLE_W-1:0]   in_sample_mv,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [scd_pkg::CODE_W-1:0]     out_adc_code,
  output logic [scd_pkg::SAMPLE_W-1:0]   out_sample_echo_mv,
  output logic [scd_pkg::RES_W-1:0]      out_sensor_ohm,
  output logic [scd_pkg::COND_W-1:0]     out_conductance_cus,
  output logic [scd_pkg::DMV_W-1:0]      out_smoothed_dmv,
  output logic                           out_clipped,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scd_pkg::CFG_DATA_W-1:0] cfg_data
);

  scd_pkg::state_t state_r, state_nxt;

  // Configuration registers
  logic [scd_pkg::ALPHA_W-1:0]  alpha_r;
  logic [scd_pkg::SUPPLY_W-1:0] supply_r;
  logic [scd_pkg::RREF_W-1:0]   rref_r;

  // Per-sample working registers
  logic [scd_pkg::SAMPLE_W-1:0]  v_r;
  logic                          clip_r;
  logic [scd_pkg::SUPPLY_W-1:0]  diff_r;
  logic [scd_pkg::CODE_W-1:0]    code_r;
  logic [scd_pkg::RES_W-1:0]     res_r;
  logic [scd_pkg::COND_W-1:0]    cond_r;
  logic [scd_pkg::DIV_DEN_W-1:0] den_r;
  logic [scd_pkg::PA_W-1:0]      pa_r;
  logic [scd_pkg::RND_W-1:0]     rnd_r;

  // Filter state
  logic [scd_pkg::AVG_W-1:0] avg_r;
  logic                      first_r;

  // Output register
  logic                         out_valid_r;
  logic [scd_pkg::CODE_W-1:0]   out_code_r;
  logic [scd_pkg::SAMPLE_W-1:0] out_echo_r;
  logic [scd_pkg::RES_W-1:0]    out_res_r;
  logic [scd_pkg::COND_W-1:0]   out_cond_r;
  logic [scd_pkg::DMV_W-1:0]    out_dmv_r;
  logic                         out_clip_r;

  // Arithmetic unit hookup
  logic                          mul_start, mul_done;
  logic [scd_pkg::MC_W-1:0]      mul_mcand;
  logic [scd_pkg::MP_W-1:0]      mul_mplier;
  logic [scd_pkg::PROD_W-1:0]    mul_prod;
  logic                          div_start, div_done;
  logic [scd_pkg::DIV_NUM_W-1:0] div_num;
  logic [scd_pkg::DIV_DEN_W-1:0] div_den;
  logic [scd_pkg::DIV_CNT_W-1:0] div_steps;
  logic [scd_pkg::DIV_NUM_W-1:0] div_quo;

  logic [scd_pkg::CODE_NUM_W-1:0] code_num;
  logic [scd_pkg::SUM_W-1:0]      ema_sum;
  logic [scd_pkg::DMV_CW-1:0]     dmv_wide;
  logic                           out_load;

  // v*4095 as shift and subtract
  assign code_num = (scd_pkg::CODE_NUM_W'(v_r) << scd_pkg::CODE_W)
                  - scd_pkg::CODE_NUM_W'(v_r);

  // EMA: (a*(v<<F) + (1-a)*avg + half) >> 16; the (1-a)*avg + half term is in rnd_r
  assign ema_sum = scd_pkg::SUM_W'(rnd_r)
                 + (scd_pkg::SUM_W'(pa_r) << scd_pkg::AVG_FRAC);

  // Average in tenths of mV, rounded half up
  assign dmv_wide = (scd_pkg::DMV_CW'(avg_r) << 3) + (scd_pkg::DMV_CW'(avg_r) << 1)
                  + scd_pkg::DMV_HALF;

  scd_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  scd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quo   (div_quo)
  );

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scd_pkg::S_IDLE: begin
        if (in_valid) state_nxt = scd_pkg::S_LOAD;
      end
      scd_pkg::S_LOAD: begin
        // zero supply: every sample clips and the code saturates
        if (supply_r == '0) state_nxt = scd_pkg::S_EMA;
        else                state_nxt = scd_pkg::S_CODE_DIV;
      end
      scd_pkg::S_CODE_DIV: begin
        if (div_done) state_nxt = clip_r ? scd_pkg::S_EMA : scd_pkg::S_RES_MUL;
      end
      scd_pkg::S_RES_MUL: begin
        if (mul_done) state_nxt = scd_pkg::S_RES_DIV;
      end
      scd_pkg::S_RES_DIV: begin
        if (div_done) state_nxt = scd_pkg::S_CND_MUL;
      end
      scd_pkg::S_CND_MUL: begin
        // zero reference resistor: conductance saturates, no division
        if (mul_done) state_nxt = (den_r == '0) ? scd_pkg::S_EMA : scd_pkg::S_CND_DIV;
      end
      scd_pkg::S_CND_DIV: begin
        if (div_done) state_nxt = scd_pkg::S_EMA;
      end
      scd_pkg::S_EMA: begin
        state_nxt = first_r ? scd_pkg::S_DONE : scd_pkg::S_EMA_MA;
      end
      scd_pkg::S_EMA_MA: begin
        if (mul_done) state_nxt = scd_pkg::S_EMA_MB;
      end
      scd_pkg::S_EMA_MB: begin
        if (mul_done) state_nxt = scd_pkg::S_EMA_SUM;
      end
      scd_pkg::S_EMA_SUM: begin
        state_nxt = scd_pkg::S_DONE;
      end
      scd_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = scd_pkg::S_IDLE;
      end
      default: begin
        state_nxt = scd_pkg::S_IDLE;
      end
    endcase
  end

  // Unit launch: operands chosen by the phase being entered
  always_comb begin
    mul_mcand  = '0;
    mul_mplier = '0;
    div_num    = '0;
    div_den    = '0;
    div_steps  = '0;
    case (state_nxt)
      scd_pkg::S_RES_MUL: begin
        mul_mcand  = scd_pkg::MC_W'(rref_r);
        mul_mplier = scd_pkg::MP_W'(v_r);
      end
      scd_pkg::S_CND_MUL: begin
        mul_mcand  = scd_pkg::MC_W'(scd_pkg::COND_SCALE);
        mul_mplier = scd_pkg::MP_W'(diff_r);
      end
      scd_pkg::S_EMA_MA: begin
        mul_mcand  = scd_pkg::MC_W'(alpha_r);
        mul_mplier = scd_pkg::MP_W'(v_r);
      end
      scd_pkg::S_EMA_MB: begin
        mul_mcand  = scd_pkg::MC_W'(avg_r);
        mul_mplier = scd_pkg::ALPHA_ONE - scd_pkg::MP_W'(alpha_r);
      end
      scd_pkg::S_CODE_DIV: begin
        div_num   = scd_pkg::DIV_NUM_W'(code_num)
                    << (scd_pkg::DIV_NUM_W - scd_pkg::CODE_NUM_W);
        div_den   = scd_pkg::DIV_DEN_W'(supply_r);
        div_steps = scd_pkg::DIV_CNT_W'(scd_pkg::CODE_NUM_W);
      end
      scd_pkg::S_RES_DIV: begin
        div_num   = scd_pkg::DIV_NUM_W'(mul_prod[scd_pkg::RES_NUM_W-1:0])
                    << (scd_pkg::DIV_NUM_W - scd_pkg::RES_NUM_W);
        div_den   = scd_pkg::DIV_DEN_W'(diff_r);
        div_steps = scd_pkg::DIV_CNT_W'(scd_pkg::RES_NUM_W);
      end
      scd_pkg::S_CND_DIV: begin
        div_num   = scd_pkg::DIV_NUM_W'(mul_prod[scd_pkg::CND_NUM_W-1:0])
                    << (scd_pkg::DIV_NUM_W - scd_pkg::CND_NUM_W);
        div_den   = den_r;
        div_steps = scd_pkg::DIV_CNT_W'(scd_pkg::CND_NUM_W);
      end
      default: begin
        mul_mcand = '0;
      end
    endcase
  end

  assign mul_start = (state_nxt != state_r) &&
                     (state_nxt inside {scd_pkg::S_RES_MUL, scd_pkg::S_CND_MUL,
                                        scd_pkg::S_EMA_MA, scd_pkg::S_EMA_MB});
  assign div_start = (state_nxt != state_r) &&
                     (state_nxt inside {scd_pkg::S_CODE_DIV, scd_pkg::S_RES_DIV,
                                        scd_pkg::S_CND_DIV});

  assign out_load = (state_r == scd_pkg::S_DONE) && (state_nxt == scd_pkg::S_IDLE);

  // Control state: configuration, filter state, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= scd_pkg::ALPHA_RST;
      supply_r    <= scd_pkg::SUPPLY_RST;
      rref_r      <= scd_pkg::RREF_RST;
      avg_r       <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          scd_pkg::CFG_ALPHA:  alpha_r  <= cfg_data[scd_pkg::ALPHA_W-1:0];
          scd_pkg::CFG_SUPPLY: supply_r <= cfg_data[scd_pkg::SUPPLY_W-1:0];
          scd_pkg::CFG_RREF:   rref_r   <= cfg_data[scd_pkg::RREF_W-1:0];
          default:             alpha_r  <= alpha_r;
        endcase
      end
      if (state_r == scd_pkg::S_EMA && first_r) begin
        avg_r   <= scd_pkg::AVG_W'(v_r) << scd_pkg::AVG_FRAC;
        first_r <= 1'b0;
      end else if (state_r == scd_pkg::S_EMA_SUM) begin
        avg_r <= ema_sum[scd_pkg::ALPHA_W +: scd_pkg::AVG_W];
      end
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      scd_pkg::S_IDLE: begin
        if (in_valid) v_r <= in_sample_mv;
      end
      scd_pkg::S_LOAD: begin
        clip_r <= (v_r == '0) || (v_r >= supply_r);
        diff_r <= supply_r - v_r;
        code_r <= scd_pkg::CODE_MAX;
        res_r  <= '0;
        cond_r <= '0;
      end
      scd_pkg::S_CODE_DIV: begin
        if (div_done) begin
          code_r <= (div_quo > scd_pkg::DIV_NUM_W'(scd_pkg::CODE_MAX))
                    ? scd_pkg::CODE_MAX : div_quo[scd_pkg::CODE_W-1:0];
        end
      end
      scd_pkg::S_RES_MUL: begin
        if (mul_done) den_r <= mul_prod[scd_pkg::DIV_DEN_W-1:0];
      end
      scd_pkg::S_RES_DIV: begin
        if (div_done) res_r <= div_quo[scd_pkg::RES_W-1:0];
      end
      scd_pkg::S_CND_MUL: begin
        if (mul_done && den_r == '0) cond_r <= scd_pkg::COND_MAX;
      end
      scd_pkg::S_CND_DIV: begin
        if (div_done) begin
          cond_r <= (div_quo > scd_pkg::DIV_NUM_W'(scd_pkg::COND_MAX))
                    ? scd_pkg::COND_MAX : div_quo[scd_pkg::COND_W-1:0];
        end
      end
      scd_pkg::S_EMA_MA: begin
        if (mul_done) pa_r <= mul_prod[scd_pkg::PA_W-1:0];
      end
      scd_pkg::S_EMA_MB: begin
        if (mul_done) rnd_r <= scd_pkg::RND_W'(mul_prod) + scd_pkg::ROUND_HALF;
      end
      default: begin
        pa_r <= pa_r;
      end
    endcase
    if (out_load) begin
      out_code_r <= code_r;
      out_echo_r <= v_r;
      out_res_r  <= res_r;
      out_cond_r <= cond_r;
      out_dmv_r  <= dmv_wide[scd_pkg::AVG_FRAC +: scd_pkg::DMV_W];
      out_clip_r <= clip_r;
    end
  end

  assign in_ready            = (state_r == scd_pkg::S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_adc_code        = out_code_r;
  assign out_sample_echo_mv  = out_echo_r;
  assign out_sensor_ohm      = out_res_r;
  assign out_conductance_cus = out_cond_r;
  assign out_smoothed_dmv    = out_dmv_r;
  assign out_clipped         = out_clip_r;

endmodule
